[rtl/aphit_pkg.sv]
// package: types, constants and arctangent table for the arc hit test
`timescale 1ns / 1ps
package aphit_pkg;

  localparam int CordicSteps  = 16;
  localparam int FractionBits = 16;
  localparam int GuardShift   = 8;
  localparam int CW           = 44;  // cordic x/y width (33 bit offset + guard + growth)
  localparam int ZW           = 34;  // q30 angle accumulator
  localparam int AngW         = 20;
  localparam int CfgIdxW      = 3;
  localparam int CfgDataW     = 32;
  localparam int QueueDepth   = 4;
  localparam int QueuePtrW    = 2;

  localparam logic signed [ZW-1:0] PiQ30 = 34'sd3373259426;
  localparam logic [31:0] InvGainQ30 = 32'd652032874;
  localparam logic signed [AngW-1:0] TwoPi =
    AngW'((2 * 64'sd3373259426 + (64'sd1 << (29 - FractionBits))) >>> (30 - FractionBits));

  typedef enum logic [CfgIdxW-1:0] {
    REG_CENTER_X   = 3'd0,
    REG_CENTER_Y   = 3'd1,
    REG_ARC_RADIUS = 3'd2,
    REG_ANG_BEGIN  = 3'd3,
    REG_ANG_FINISH = 3'd4,
    REG_HIT_TOL    = 3'd5
  } cfg_reg_e;

  typedef struct packed {
    logic signed [32:0] dx;
    logic signed [32:0] dy;
  } offset_t;

  typedef struct packed {
    logic on_arc;
    logic radius_ok;
    logic angle_ok;
  } hit_t;

  function automatic logic signed [ZW-1:0] atan_q30(input int s);
    logic signed [ZW-1:0] r;
    unique case (s)
      0: r = 34'sd843314857;
      1: r = 34'sd497837829;
      2: r = 34'sd263043837;
      3: r = 34'sd133525159;
      4: r = 34'sd67021687;
      5: r = 34'sd33543516;
      6: r = 34'sd16775851;
      7: r = 34'sd8388437;
      8: r = 34'sd4194283;
      9: r = 34'sd2097149;
      default: r = (s < 31) ? (34'sd1 <<< (30 - s)) : 34'sd0;
    endcase
    return r;
  endfunction

endpackage

[rtl/aphit_front.sv]
// front end: takes point beats and forms the offset from the arc centre
`timescale 1ns / 1ps
module aphit_front (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  input  logic [63:0]               s_axis_tdata,
  input  logic signed [31:0]        center_x_i,
  input  logic signed [31:0]        center_y_i,
  output logic                      valid_o,
  input  logic                      ready_i,
  output aphit_pkg::offset_t        off_o
);
  import aphit_pkg::*;

  logic    valid_q;
  offset_t off_q;

  assign s_axis_tready = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      off_q.dx <= 33'($signed(s_axis_tdata[31:0]))  - 33'(center_x_i);
      off_q.dy <= 33'($signed(s_axis_tdata[63:32])) - 33'(center_y_i);
    end
  end

  assign valid_o = valid_q;
  assign off_o   = off_q;
endmodule

[rtl/aphit_queue.sv]
// short fifo between front and back ends
`timescale 1ns / 1ps
module aphit_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  aphit_pkg::offset_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output aphit_pkg::offset_t  out_data_o
);
  import aphit_pkg::*;

  offset_t             mem_q [QueueDepth];
  logic [QueuePtrW-1:0] wr_q, rd_q;
  logic [QueuePtrW:0]   cnt_q;
  logic                 push, pop;

  assign in_ready_o  = cnt_q != (QueuePtrW+1)'(QueueDepth);
  assign out_valid_o = cnt_q != '0;
  assign push        = in_valid_i && in_ready_o;
  assign pop         = out_valid_o && out_ready_i;
  assign out_data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= in_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) wr_q <= wr_q + 1'b1;
      if (pop)  rd_q <= rd_q + 1'b1;
      cnt_q <= cnt_q + (QueuePtrW+1)'(push) - (QueuePtrW+1)'(pop);
    end
  end
endmodule

[rtl/aphit_back.sv]
// back end: pipelined cordic vectoring, gain scaling and range checks
`timescale 1ns / 1ps
module aphit_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  output logic               ready_o,
  input  aphit_pkg::offset_t off_i,
  input  logic [30:0]        arc_radius_i,
  input  logic [18:0]        angle_begin_i,
  input  logic [18:0]        angle_finish_i,
  input  logic [30:0]        hit_tolerance_i,
  output logic               valid_o,
  input  logic               ready_i,
  output aphit_pkg::hit_t    hit_o
);
  import aphit_pkg::*;

  localparam int NS = CordicSteps + 3;  // prep, steps, mul, round

  logic                  v_q [NS];
  logic signed [CW-1:0]  x_q [CordicSteps+1];
  logic signed [CW-1:0]  y_q [CordicSteps+1];
  logic signed [ZW-1:0]  z_q [CordicSteps+1];
  logic                  zero_q [CordicSteps+2];
  logic                  adv;

  logic [63:0]           plo_q, phi_q;
  logic signed [ZW-1:0]  zm_q;
  logic [34:0]           dist_q;
  logic signed [AngW-1:0] ang_q;
  hit_t                  hit_q;
  logic                  ovalid_q;

  // whole pipe advances together; output register frees when taken
  assign adv     = !ovalid_q || ready_i;
  assign ready_o = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NS; i++) v_q[i] <= 1'b0;
      ovalid_q <= 1'b0;
    end else if (adv) begin
      v_q[0] <= valid_i;
      for (int i = 1; i < NS; i++) v_q[i] <= v_q[i-1];
      ovalid_q <= v_q[NS-1];
    end
  end

  // prep: guard scaling and half-plane fold
  always_ff @(posedge clk_i) begin
    if (adv) begin
      zero_q[0] <= (off_i.dx == '0) && (off_i.dy == '0);
      if (off_i.dx < 0) begin
        x_q[0] <= -(CW'(off_i.dx) <<< GuardShift);
        y_q[0] <= -(CW'(off_i.dy) <<< GuardShift);
        z_q[0] <= (off_i.dy < 0) ? -PiQ30 : PiQ30;
      end else begin
        x_q[0] <= CW'(off_i.dx) <<< GuardShift;
        y_q[0] <= CW'(off_i.dy) <<< GuardShift;
        z_q[0] <= '0;
      end
    end
  end

  for (genvar g = 0; g < CordicSteps; g++) begin : g_step
    always_ff @(posedge clk_i) begin
      if (adv) begin
        zero_q[g+1] <= zero_q[g];
        if (y_q[g] >= 0) begin
          x_q[g+1] <= x_q[g] + (y_q[g] >>> (g % 32));
          y_q[g+1] <= y_q[g] - (x_q[g] >>> (g % 32));
          z_q[g+1] <= z_q[g] + atan_q30(g % 32);
        end else begin
          x_q[g+1] <= x_q[g] - (y_q[g] >>> (g % 32));
          y_q[g+1] <= y_q[g] + (x_q[g] >>> (g % 32));
          z_q[g+1] <= z_q[g] - atan_q30(g % 32);
        end
      end
    end
  end

  // gain: two partial products of the final x
  logic [CW-1:0] xf;
  assign xf = x_q[CordicSteps];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      plo_q <= 64'(xf[31:0]) * 64'(InvGainQ30);
      phi_q <= 64'(xf[CW-1:32]) * 64'(InvGainQ30);
      zm_q  <= z_q[CordicSteps];
      zero_q[CordicSteps+1] <= zero_q[CordicSteps];
    end
  end

  logic [63:0] scaled;
  logic signed [ZW-1:0] zr;
  logic signed [AngW-1:0] a0;
  assign scaled = (phi_q << 2) + ((plo_q + (64'd1 << 29)) >> 30);
  assign zr = (zm_q + (ZW'(1) <<< (29 - FractionBits))) >>> (30 - FractionBits);
  assign a0 = AngW'(zr);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      dist_q <= 35'((scaled + 64'd128) >> GuardShift);
      if (zero_q[CordicSteps+1]) ang_q <= '0;
      else if (a0 < 0)           ang_q <= a0 + TwoPi;
      else if (a0 >= TwoPi)      ang_q <= a0 - TwoPi;
      else                       ang_q <= a0;
    end
  end

  logic signed [35:0] diff;
  logic [35:0]        adiff;
  logic               r_ok, a_ok, ge_b, le_f;
  always_comb begin
    diff  = $signed({1'b0, dist_q}) - $signed(36'(arc_radius_i));
    adiff = diff < 0 ? 36'(-diff) : 36'(diff);
    r_ok  = adiff <= 36'(hit_tolerance_i);
    ge_b  = ang_q >= $signed(AngW'(angle_begin_i));
    le_f  = ang_q <= $signed(AngW'(angle_finish_i));
    a_ok  = (angle_finish_i >= angle_begin_i) ? (ge_b && le_f) : (ge_b || le_f);
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      hit_q.on_arc    <= r_ok && a_ok;
      hit_q.radius_ok <= r_ok;
      hit_q.angle_ok  <= a_ok;
    end
  end

  assign valid_o = ovalid_q;
  assign hit_o   = hit_q;
endmodule

[rtl/arc_point_hit_test.sv]
// top level: arc hit test with config registers, front end, queue and cordic back end
`timescale 1ns / 1ps
// Usage
//   s_axis carries one point per beat, m_axis one result per beat.
//   Configuration goes through cfg_we_i / cfg_idx_i / cfg_data_i; the user must
//   write it only while no point is in flight, which the block does not enforce.
//   Path: the front register, the queue, then the back end stages in order
//   (prep, 16 cordic steps, gain multiply, rounding and fold, output register
//   with range checks).
//   Throughput is one point per cycle while m_axis does not stall; the back end is a straight pipeline
//   with one cordic step per stage.
//   When m_axis stalls the back end halts as a whole, the four-entry queue
//   fills and the front end then drops s_axis_tready.
//   Reset clears all valid flags and the queue and loads the default
//   registers: centre at origin, radius 1.0, full circle, zero tolerance.
module arc_point_hit_test (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // point_x, point_y
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // on_arc, radius_ok, angle_ok, zero fill
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i
);
  import aphit_pkg::*;

  logic signed [31:0] cx_q, cy_q;
  logic [30:0] rad_q, tol_q;
  logic [18:0] ab_q, af_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cx_q  <= '0;
      cy_q  <= '0;
      rad_q <= 31'd65536;
      ab_q  <= '0;
      af_q  <= 19'd411775;
      tol_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_CENTER_X:   cx_q  <= cfg_data_i;
        REG_CENTER_Y:   cy_q  <= cfg_data_i;
        REG_ARC_RADIUS: rad_q <= cfg_data_i[30:0];
        REG_ANG_BEGIN:  ab_q  <= cfg_data_i[18:0];
        REG_ANG_FINISH: af_q  <= cfg_data_i[18:0];
        REG_HIT_TOL:    tol_q <= cfg_data_i[30:0];
        default: ;
      endcase
    end
  end

  logic    f_valid, f_ready, q_valid, q_ready;
  offset_t f_off, q_off;
  hit_t    hit;

  aphit_front u_front (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .center_x_i(cx_q), .center_y_i(cy_q),
    .valid_o(f_valid), .ready_i(f_ready), .off_o(f_off)
  );

  aphit_queue u_queue (
    .clk_i, .rst_ni,
    .in_valid_i(f_valid), .in_ready_o(f_ready), .in_data_i(f_off),
    .out_valid_o(q_valid), .out_ready_i(q_ready), .out_data_o(q_off)
  );

  aphit_back u_back (
    .clk_i, .rst_ni,
    .valid_i(q_valid), .ready_o(q_ready), .off_i(q_off),
    .arc_radius_i(rad_q), .angle_begin_i(ab_q), .angle_finish_i(af_q),
    .hit_tolerance_i(tol_q),
    .valid_o(m_axis_tvalid), .ready_i(m_axis_tready), .hit_o(hit)
  );

  assign m_axis_tdata = {5'b0, hit.angle_ok, hit.radius_ok, hit.on_arc};
endmodule
